@@ rtl/id3p_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_pkg
// Types, codes and constant tables shared by the ID3v2.3 tag stream parser.
// ----------------------------------------------------------------------------
package id3p_pkg;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd2;
    localparam logic [2:0] PH_FLAGS  = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_IDLE   = 3'd6;

    // result event codes
    localparam logic [2:0] EV_HDR_OK   = 3'd0;
    localparam logic [2:0] EV_HDR_BAD  = 3'd1;
    localparam logic [2:0] EV_FR_START = 3'd2;
    localparam logic [2:0] EV_DATA     = 3'd3;
    localparam logic [2:0] EV_TAG_END  = 3'd4;
    localparam logic [2:0] EV_FR_SKIP  = 3'd5;

    localparam logic [3:0] KIND_NONE = 4'd11;
    localparam int unsigned NUM_KINDS = 11;

    localparam logic [15:0] SHOW_LIMIT_RST = 16'd256;

    typedef struct packed {
        logic [2:0]  ev;
        logic [3:0]  kind;
        logic [31:0] value;
        logic        flast;
    } t_result;

    // one queue entry holds every result caused by one input byte
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [31:0] kind_id(input logic [3:0] k);
        case (k)
            4'd0:    kind_id = 32'h54495432; // TIT2
            4'd1:    kind_id = 32'h54504531; // TPE1
            4'd2:    kind_id = 32'h54414C42; // TALB
            4'd3:    kind_id = 32'h54594552; // TYER
            4'd4:    kind_id = 32'h54434F4E; // TCON
            4'd5:    kind_id = 32'h434F4D4D; // COMM
            4'd6:    kind_id = 32'h54505542; // TPUB
            4'd7:    kind_id = 32'h54434F4D; // TCOM
            4'd8:    kind_id = 32'h54504532; // TPE2
            4'd9:    kind_id = 32'h544F5045; // TOPE
            4'd10:   kind_id = 32'h54454E43; // TENC
            default: kind_id = 32'h00000000;
        endcase
    endfunction

    // fixed bytes at the head of the tag: I D 3, version, revision
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
        case (idx)
            4'd0:    hdr_byte = 8'h49;
            4'd1:    hdr_byte = 8'h44;
            4'd2:    hdr_byte = 8'h33;
            4'd3:    hdr_byte = 8'h03;
            default: hdr_byte = 8'h00;
        endcase
    endfunction

endpackage

@@ rtl/id3p_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_front
// Byte parser: walks the header and frame fields and builds one queue entry
// for every byte that causes results.
// ----------------------------------------------------------------------------
module id3p_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_file_start,
    input  logic [15:0]       i_show_limit,
    output logic              o_push,
    output id3p_pkg::t_entry  o_entry
);
    import id3p_pkg::*;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_fcnt, n_fcnt;
    logic [27:0] r_tag, n_tag;
    logic [31:0] r_proc, n_proc;
    logic [31:0] r_proc_new, n_proc_new;
    logic [31:0] r_id, n_id;
    logic [31:0] r_fsize, n_fsize;
    logic [31:0] r_left, n_left;
    logic [3:0]  r_kind, n_kind;
    logic        r_first, n_first;

    logic [2:0]  c_phase;
    logic [3:0]  c_fcnt, fc_inc;
    logic [27:0] c_tag;
    logic [33:0] sum;
    logic [3:0]  match;
    logic        p_valid, e_valid;
    t_result     p_res, e_res;
    logic        fin;

    // file_start restarts the walk on this very byte
    assign c_phase = i_file_start ? PH_HEADER : r_phase;
    assign c_fcnt  = i_file_start ? 4'd0 : r_fcnt;
    assign c_tag   = i_file_start ? 28'd0 : r_tag;
    assign fc_inc  = c_fcnt + 4'd1;

    assign sum = {2'b00, r_proc} + {2'b00, r_fsize} + 34'd10;

    always_comb begin
        match = KIND_NONE;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if ({r_id[23:0], i_data_byte} == kind_id(4'(k))) begin
                match = 4'(k);
            end
        end
    end

    always_comb begin
        n_phase    = c_phase;
        n_fcnt     = c_fcnt;
        n_tag      = c_tag;
        n_proc     = r_proc;
        n_proc_new = r_proc_new;
        n_id       = r_id;
        n_fsize    = r_fsize;
        n_left     = r_left;
        n_kind     = r_kind;
        n_first    = r_first;
        p_valid    = 1'b0;
        p_res      = '0;
        e_valid    = 1'b0;
        e_res      = '0;
        e_res.ev   = EV_TAG_END;
        fin        = 1'b0;

        case (c_phase)
            PH_HEADER: begin
                if (c_fcnt < 4'd5 && i_data_byte != hdr_byte(c_fcnt)) begin
                    p_valid  = 1'b1;
                    p_res.ev = EV_HDR_BAD;
                    n_phase  = PH_IDLE;
                end else begin
                    if (c_fcnt >= 4'd6) begin
                        n_tag = {c_tag[20:0], i_data_byte[6:0]};
                    end
                    n_fcnt = fc_inc;
                    if (fc_inc >= 4'd10) begin
                        p_valid     = 1'b1;
                        p_res.ev    = EV_HDR_OK;
                        p_res.value = {4'd0, n_tag};
                        n_proc      = '0;
                        n_fcnt      = '0;
                        n_id        = '0;
                        if (n_tag == 28'd0) begin
                            e_valid = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_ID;
                        end
                    end
                end
            end
            PH_ID: begin
                n_id   = {r_id[23:0], i_data_byte};
                n_fcnt = fc_inc;
                if (fc_inc >= 4'd4) begin
                    n_kind  = match;
                    n_fsize = '0;
                    n_fcnt  = '0;
                    n_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                n_fsize = {r_fsize[23:0], i_data_byte};
                n_fcnt  = fc_inc;
                if (fc_inc >= 4'd4) begin
                    n_fcnt = '0;
                    if (n_fsize == 32'd0 || r_kind == KIND_NONE) begin
                        e_valid     = 1'b1;
                        e_res.value = r_proc;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_phase = PH_FLAGS;
                    end
                end
            end
            PH_FLAGS: begin
                n_fcnt = fc_inc;
                if (fc_inc >= 4'd2) begin
                    n_fcnt     = '0;
                    n_left     = r_fsize;
                    n_first    = 1'b1;
                    // running total after this frame, settled ahead of its end
                    n_proc_new = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
                    p_valid     = 1'b1;
                    p_res.kind  = r_kind;
                    p_res.value = r_fsize;
                    if (r_fsize < {16'd0, i_show_limit}) begin
                        p_res.ev = EV_FR_START;
                        n_phase  = PH_DATA;
                    end else begin
                        p_res.ev = EV_FR_SKIP;
                        n_phase  = PH_SKIP;
                    end
                end
            end
            PH_DATA: begin
                // the encoding byte leads the frame and is not shown
                if (!r_first) begin
                    p_valid     = 1'b1;
                    p_res.ev    = EV_DATA;
                    p_res.kind  = r_kind;
                    p_res.value = {24'd0, i_data_byte};
                    p_res.flast = (r_left == 32'd1);
                end
                n_first = 1'b0;
                n_left  = r_left - 32'd1;
                fin     = (r_left == 32'd1);
            end
            PH_SKIP: begin
                n_left = r_left - 32'd1;
                fin    = (r_left == 32'd1);
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (fin) begin
            n_proc = r_proc_new;
            n_fcnt = '0;
            n_id   = '0;
            if (r_proc_new >= {4'd0, r_tag}) begin
                e_valid     = 1'b1;
                e_res.value = r_proc_new;
                n_phase     = PH_IDLE;
            end else begin
                n_phase = PH_ID;
            end
        end
    end

    always_comb begin
        o_push = i_accept && (p_valid || e_valid);
        if (p_valid) begin
            o_entry.two = e_valid;
            o_entry.r0  = p_res;
            o_entry.r1  = e_res;
        end else begin
            o_entry.two = 1'b0;
            o_entry.r0  = e_res;
            o_entry.r1  = e_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_fcnt     <= '0;
            r_tag      <= '0;
            r_proc     <= '0;
            r_proc_new <= '0;
            r_id       <= '0;
            r_fsize    <= '0;
            r_left     <= '0;
            r_kind     <= '0;
            r_first    <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_fcnt     <= n_fcnt;
            r_tag      <= n_tag;
            r_proc     <= n_proc;
            r_proc_new <= n_proc_new;
            r_id       <= n_id;
            r_fsize    <= n_fsize;
            r_left     <= n_left;
            r_kind     <= n_kind;
            r_first    <= n_first;
        end
    end

endmodule

@@ rtl/id3p_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_fifo
// Small entry queue between the byte parser and the result sequencer.
// ----------------------------------------------------------------------------
module id3p_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  id3p_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output id3p_pkg::t_entry    o_head,
    output id3p_pkg::t_q_status o_status
);
    import id3p_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

endmodule

@@ rtl/id3p_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_back
// Result sequencer: unpacks queue entries into single results and holds
// them in the output register.
// ----------------------------------------------------------------------------
module id3p_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  id3p_pkg::t_entry    i_head,
    input  id3p_pkg::t_q_status i_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_event_res,
    output logic [3:0]          o_frame_kind,
    output logic [31:0]         o_value,
    output logic                o_frame_last,
    output logic                o_run_last
);
    import id3p_pkg::*;

    logic    r_valid;
    logic    r_sel;
    t_result r_res;
    logic    r_run_last;
    logic    load, last_of_entry;

    assign load          = !i_status.empty && (!r_valid || i_out_ready);
    assign last_of_entry = r_sel || !i_head.two;
    assign o_pop         = load && last_of_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !last_of_entry;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res      <= r_sel ? i_head.r1 : i_head.r0;
            r_run_last <= last_of_entry;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_event_res  = r_res.ev;
    assign o_frame_kind = r_res.kind;
    assign o_value      = r_res.value;
    assign o_frame_last = r_res.flast;
    assign o_run_last   = r_run_last;

    // second half of an entry is only pending while that entry is at the head
    a_sel_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (!i_status.empty && i_head.two))
        else $error("second result pending without entry");

endmodule

@@ rtl/id3v23_tag_stream_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v23_tag_stream_parser
// ID3v2.3 tag parser: checks the header and walks the text frames of a byte
// stream, reporting header, frame, data byte and tag end events.
//
//   channel | direction | signals
//   in      | in        | i_in_valid, o_in_ready, i_data_byte, i_file_start
//   out     | out       | o_out_valid, i_out_ready, o_event_res, o_frame_kind,
//           |           | o_value, o_frame_last, o_run_last
//   cfg     | in        | i_cfg_valid, o_cfg_ready, i_cfg_data (show_limit)
//
// One byte is accepted per cycle while the entry queue has room; the byte
// parser decides all results of a byte in the cycle it is accepted.
// The output side delivers one result per cycle while i_out_ready is high, so a
// byte with two results needs two output transfers; the queue of QUEUE_DEPTH entries absorbs that.
// An output stall backs up into the queue and then drops o_in_ready.
// Synchronous reset returns to the header phase with show_limit at 256.
// ----------------------------------------------------------------------------
module id3v23_tag_stream_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_frame_kind,
    output logic [31:0] o_value,
    output logic        o_frame_last,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import id3p_pkg::*;

    logic [15:0] r_show_limit;
    logic        accept;
    logic        push, pop;
    t_entry      push_entry, head;
    t_q_status   q_status;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_status.full;
    assign accept      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_limit <= SHOW_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_show_limit <= i_cfg_data;
        end
    end

    id3p_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .i_show_limit (r_show_limit),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    id3p_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    id3p_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_status     (q_status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_frame_kind (o_frame_kind),
        .o_value      (o_value),
        .o_frame_last (o_frame_last),
        .o_run_last   (o_run_last)
    );

endmodule

@@ sim/id3v23_tag_stream_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v23_tag_stream_parser_tb
// Self-checking bench for the ID3v2.3 tag stream parser. Byte streams of
// directed and random tag files are sent through the input channel, a
// byte-level parser model inside the bench predicts every result, and each
// result on the output channel is checked field by field against it.
// ----------------------------------------------------------------------------
module id3v23_tag_stream_parser_tb;

    import id3p_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]  ev;
        logic [3:0]  kind;
        logic [31:0] value;
        logic        frame_last;
        logic        run_last;
    } tag_event_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_file_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic [3:0]  o_frame_kind;
    logic [31:0] o_value;
    logic        o_frame_last;
    logic        o_run_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'd0;

    // parser model state
    logic [15:0] show_limit = SHOW_LIMIT_RST;
    logic [2:0]  pr_phase = PH_HEADER;
    int unsigned pr_count = 0;
    logic [27:0] pr_tag_size = '0;
    logic [31:0] pr_total = '0;
    logic [31:0] pr_id = '0;
    logic [31:0] pr_size = '0;
    logic [31:0] pr_left = '0;
    logic [3:0]  pr_kind = '0;

    tag_event_t  step_res [2];
    int          step_n;
    tag_event_t  pending_events [$];
    logic [8:0]  file_bytes [$];     // {file_start, data byte}

    int          mismatches = 0;
    int unsigned stall_cycles = 0;
    int unsigned bytes_parsed = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    id3v23_tag_stream_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_frame_kind (o_frame_kind),
        .o_value      (o_value),
        .o_frame_last (o_frame_last),
        .o_run_last   (o_run_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function automatic logic [31:0] frame_code(input int k);
        case (k)
            0:       frame_code = "TIT2";
            1:       frame_code = "TPE1";
            2:       frame_code = "TALB";
            3:       frame_code = "TYER";
            4:       frame_code = "TCON";
            5:       frame_code = "COMM";
            6:       frame_code = "TPUB";
            7:       frame_code = "TCOM";
            8:       frame_code = "TPE2";
            9:       frame_code = "TOPE";
            10:      frame_code = "TENC";
            default: frame_code = 32'h0;
        endcase
    endfunction

    function automatic logic [7:0] header_magic(input int unsigned idx);
        case (idx)
            0:       header_magic = "I";
            1:       header_magic = "D";
            2:       header_magic = "3";
            3:       header_magic = 8'h03;
            default: header_magic = 8'h00;
        endcase
    endfunction

    function automatic void add_event(input logic [2:0] ev, input logic [3:0] kind,
                                      input logic [31:0] val, input logic flast);
        step_res[step_n] = {ev, kind, val, flast, 1'b0};
        step_n++;
    endfunction

    function automatic void finish_frame();
        logic [33:0] sum;
        sum = {2'b00, pr_total} + {2'b00, pr_size} + 34'd10;
        pr_total = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
        pr_count = 0;
        pr_id = '0;
        if (pr_total >= {4'd0, pr_tag_size}) begin
            add_event(EV_TAG_END, 4'd0, pr_total, 1'b0);
            pr_phase = PH_IDLE;
        end else begin
            pr_phase = PH_ID;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic fs);
        int i;
        step_n = 0;
        if (fs) begin
            pr_phase = PH_HEADER;
            pr_count = 0;
            pr_tag_size = '0;
            pr_total = '0;
            pr_id = '0;
            pr_size = '0;
            pr_left = '0;
            pr_kind = '0;
        end
        case (pr_phase)
            PH_HEADER: begin
                if (pr_count < 5 && b != header_magic(pr_count)) begin
                    add_event(EV_HDR_BAD, 4'd0, 32'd0, 1'b0);
                    pr_phase = PH_IDLE;
                end else begin
                    // flags byte is skipped, the last four carry 7 size bits each
                    if (pr_count >= 6)
                        pr_tag_size = {pr_tag_size[20:0], b[6:0]};
                    pr_count++;
                    if (pr_count >= 10) begin
                        add_event(EV_HDR_OK, 4'd0, {4'd0, pr_tag_size}, 1'b0);
                        pr_total = '0;
                        pr_count = 0;
                        pr_id = '0;
                        if (pr_tag_size == '0) begin
                            add_event(EV_TAG_END, 4'd0, pr_total, 1'b0);
                            pr_phase = PH_IDLE;
                        end else begin
                            pr_phase = PH_ID;
                        end
                    end
                end
            end
            PH_ID: begin
                pr_id = {pr_id[23:0], b};
                pr_count++;
                if (pr_count >= 4) begin
                    pr_kind = KIND_NONE;
                    for (i = 0; i < NUM_KINDS; i++)
                        if (pr_kind == KIND_NONE && pr_id == frame_code(i))
                            pr_kind = i[3:0];
                    pr_size = '0;
                    pr_count = 0;
                    pr_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                pr_size = {pr_size[23:0], b};
                pr_count++;
                if (pr_count >= 4) begin
                    pr_count = 0;
                    if (pr_size == '0 || pr_kind == KIND_NONE) begin
                        add_event(EV_TAG_END, 4'd0, pr_total, 1'b0);
                        pr_phase = PH_IDLE;
                    end else begin
                        pr_phase = PH_FLAGS;
                    end
                end
            end
            PH_FLAGS: begin
                pr_count++;
                if (pr_count >= 2) begin
                    pr_count = 0;
                    pr_left = pr_size;
                    if (pr_size < {16'd0, show_limit}) begin
                        add_event(EV_FR_START, pr_kind, pr_size, 1'b0);
                        pr_phase = PH_DATA;
                    end else begin
                        add_event(EV_FR_SKIP, pr_kind, pr_size, 1'b0);
                        pr_phase = PH_SKIP;
                    end
                end
            end
            PH_DATA: begin
                // first data byte is the text encoding and is not shown
                if (pr_left != pr_size)
                    add_event(EV_DATA, pr_kind, {24'd0, b}, pr_left == 32'd1);
                pr_left--;
                if (pr_left == '0)
                    finish_frame();
            end
            PH_SKIP: begin
                pr_left--;
                if (pr_left == '0)
                    finish_frame();
            end
            default: pr_phase = PH_IDLE;
        endcase
        if (step_n > 0)
            step_res[step_n - 1].run_last = 1'b1;
        for (i = 0; i < step_n; i++)
            pending_events.push_back(step_res[i]);
    endfunction

    task automatic check_result();
        tag_event_t want;
        if (pending_events.size() == 0) begin
            $error("unexpected result: event_res %0d value %0h", o_event_res, o_value);
            mismatches++;
        end else begin
            want = pending_events.pop_front();
            if (o_event_res !== want.ev) begin
                $error("event_res: expected %0d, got %0d", want.ev, o_event_res);
                mismatches++;
            end
            if (o_frame_kind !== want.kind) begin
                $error("frame_kind: expected %0d, got %0d", want.kind, o_frame_kind);
                mismatches++;
            end
            if (o_value !== want.value) begin
                $error("value: expected %0h, got %0h", want.value, o_value);
                mismatches++;
            end
            if (o_frame_last !== want.frame_last) begin
                $error("frame_last: expected %0b, got %0b", want.frame_last, o_frame_last);
                mismatches++;
            end
            if (o_run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                show_limit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                if (pr_phase != PH_IDLE || i_file_start)
                    bytes_parsed++;
                parse_byte(i_data_byte, i_file_start);
            end
            if (o_out_valid && i_out_ready)
                check_result();
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fs);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_file_start <= fs;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_file();
        foreach (file_bytes[j])
            send_byte(file_bytes[j][7:0], file_bytes[j][8]);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_show_limit(input logic [15:0] lim);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void push_byte(input logic fs, input logic [7:0] b);
        file_bytes.push_back({fs, b});
    endfunction

    function automatic void put_header(input logic [27:0] tsz);
        int i;
        for (i = 0; i < 5; i++)
            push_byte(i == 0, header_magic(i));
        push_byte(1'b0, 8'($urandom));
        // top bit of each size byte is not part of the size
        for (i = 3; i >= 0; i--)
            push_byte(1'b0, {$urandom_range(1) == 1, tsz[7 * i +: 7]});
    endfunction

    function automatic void put_frame(input logic [31:0] id, input logic [31:0] sz,
                                      input int unsigned ndata);
        int i;
        for (i = 3; i >= 0; i--)
            push_byte(1'b0, id[8 * i +: 8]);
        for (i = 3; i >= 0; i--)
            push_byte(1'b0, sz[8 * i +: 8]);
        repeat (2) push_byte(1'b0, 8'($urandom));
        repeat (ndata) push_byte(1'b0, 8'($urandom));
    endfunction

    function automatic void build_random_file();
        int          pick;
        int          nfr;
        int          i;
        int unsigned idx;
        logic [31:0] sz;
        logic [31:0] total;
        logic [31:0] tsz;
        logic        huge;
        logic [8:0]  tmp;
        logic [8:0]  body [$];
        file_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise
            repeat ($urandom_range(16, 1))
                push_byte($urandom_range(3) == 0, 8'($urandom));
        end else begin
            nfr = $urandom_range(4, 1);
            total = '0;
            huge = 1'b0;
            for (i = 0; i < nfr && !huge; i++) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    sz = $urandom_range(12, 1);
                end else if (pick < 85) begin
                    sz = $urandom_range(48, 13);
                end else begin
                    sz = $urandom | 32'h1;
                    huge = 1'b1;
                end
                put_frame(frame_code($urandom_range(10)), sz,
                          huge ? $urandom_range(8) : sz);
                total = total + sz + 32'd10;
            end
            body = file_bytes;
            file_bytes.delete();
            pick = $urandom_range(99);
            if (huge)
                tsz = $urandom;
            else if (pick < 45)
                tsz = total;
            else if (pick < 60)
                tsz = total - $urandom_range(9);
            else if (pick < 65)
                tsz = '0;
            else
                tsz = total + 32'd1 + ($urandom & 32'h07FF_FFFF);
            put_header(tsz[27:0]);
            file_bytes = {file_bytes, body};
            // stop marker: zero size or an unknown frame id
            if (!huge && pick >= 65) begin
                if ($urandom_range(1) == 0)
                    put_frame(frame_code($urandom_range(10)), 32'd0, 0);
                else
                    put_frame({8'h58, 24'($urandom)}, $urandom, 0);
            end
            if ($urandom_range(99) < 12) begin
                idx = $urandom_range(file_bytes.size() - 1);
                tmp = file_bytes[idx];
                tmp[7:0] = tmp[7:0] ^ 8'($urandom_range(255, 1));
                file_bytes[idx] = tmp;
            end
            if ($urandom_range(99) < 5) begin
                idx = $urandom_range(file_bytes.size() - 1);
                tmp = file_bytes[idx];
                tmp[8] = 1'b1;
                file_bytes[idx] = tmp;
            end
            repeat ($urandom_range(3))
                push_byte(1'b0, 8'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_header_errors();
        int pos;
        int j;
        for (pos = 0; pos < 5; pos++) begin
            file_bytes.delete();
            for (j = 0; j < pos; j++)
                push_byte(j == 0, header_magic(j));
            push_byte(pos == 0, header_magic(pos) ^ 8'($urandom_range(255, 1)));
            repeat (2) push_byte(1'b0, 8'($urandom));
            send_file();
        end
        // empty tag, flags byte all ones and last size byte with the top bit set
        file_bytes.delete();
        put_header(28'd0);
        file_bytes[5] = 9'h0FF;
        file_bytes[9] = 9'h080;
        push_byte(1'b0, 8'hFF);
        send_file();
    endtask

    task automatic test_frame_walk();
        // encoding-only frame, short frame, skipped frame, tag end after last
        file_bytes.delete();
        put_header(28'd334);
        put_frame(frame_code(0), 32'd1, 1);
        put_frame(frame_code(10), 32'd3, 3);
        put_frame(frame_code(5), 32'd300, 300);
        push_byte(1'b0, 8'($urandom));
        send_file();
        // unknown id ends the walk
        file_bytes.delete();
        put_header(28'd1000);
        put_frame(frame_code(2), 32'd2, 2);
        put_frame("XYZW", 32'd5, 0);
        send_file();
        // zero frame size ends the walk
        file_bytes.delete();
        put_header(28'hFFF_FFFF);
        put_frame(frame_code(1), 32'd0, 0);
        send_file();
        // pause mid-stream until all results are out
        settle();
    endtask

    task automatic test_limit_extremes();
        logic [15:0] lims [3];
        int i;
        lims = '{16'd0, 16'd1, 16'hFFFF};
        for (i = 0; i < 3; i++) begin
            write_show_limit(lims[i]);
            file_bytes.delete();
            put_header(28'd24);
            put_frame(frame_code(3), 32'd2, 2);
            put_frame(frame_code(4), 32'd2, 2);
            send_file();
        end
        // long frames cut short by the next file
        file_bytes.delete();
        put_header(28'h0FF_FFFF);
        put_frame(frame_code(7), 32'h0000_FFFE, 5);
        send_file();
        file_bytes.delete();
        put_header(28'h0FF_FFFF);
        put_frame(frame_code(9), 32'hFFFF_FFFF, 3);
        send_file();
    endtask

    task automatic test_random_files(input int idle, input int stall,
                                     input logic [15:0] lim);
        int unsigned goal;
        int          files;
        write_show_limit(lim);
        send_idle_pct = idle;
        stall_pct = stall;
        goal = bytes_parsed + 40;
        files = 0;
        while (bytes_parsed < goal) begin
            build_random_file();
            send_file();
            files++;
            if (files == 6)
                settle();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_errors();
        test_frame_walk();
        test_limit_extremes();
        test_random_files(0, 0, 16'($urandom_range(40, 13)));
        test_random_files(88, 0, 16'hFFFF);
        test_random_files(0, 88, 16'd1);
        test_random_files(22, 22, 16'($urandom_range(64, 2)));

        settle();
        repeat (12) @(posedge i_clk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/id3p_pkg.sv
rtl/id3p_front.sv
rtl/id3p_fifo.sv
rtl/id3p_back.sv
rtl/id3v23_tag_stream_parser.sv
sim/id3v23_tag_stream_parser_tb.sv
